[design/pgf_pkg.sv]
// ----------------------------------------------------------------------------
// pgf_pkg: shared constants for the pairwise gravity force block
// Field widths, register indexes, reset values, pipeline sizes and output limits.
// ----------------------------------------------------------------------------
package pgf_pkg;

	// Field widths
	localparam int POS_W   = 24;
	localparam int MASS_W  = 16;
	localparam int GRAV_W  = 32;
	localparam int DSQ_W   = 51;
	localparam int FORCE_W = 32;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONSTANT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_SQ   = 2'd2;

	// Register reset values
	localparam logic [GRAV_W-1:0] GRAV_RESET    = 32'd65536;
	localparam logic [DSQ_W-1:0]  MIN_DSQ_RESET = 51'd327680;
	localparam logic [DSQ_W-1:0]  MAX_DSQ_RESET = 51'd6553600;

	// Normalized radicand and square root
	localparam int NORM_W      = 62;
	localparam int ROOT_W      = 31;
	localparam int SQRT_STAGES = 31;

	// Output limits
	localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7fffffff;
	localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h80000000;

endpackage

[design/pgf_div.sv]
// ----------------------------------------------------------------------------
// pgf_div: pipelined restoring divider
// One quotient bit per stage; the partial remainder enters preloaded so the
// caller can skip leading quotient bits known to be zero.
// ----------------------------------------------------------------------------
module pgf_div #(
	parameter int DEN_W  = 51,
	parameter int Q_W    = 64,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [DEN_W-1:0]  rem_in,
	input  logic [Q_W-1:0]    num_in,
	input  logic [DEN_W-1:0]  den_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [Q_W-1:0]    quo_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    shf_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic              vld_s  [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W-1:0]  rem_p;
		logic [Q_W-1:0]    shf_p;
		logic [DEN_W-1:0]  den_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_p  = rem_in;
			assign shf_p  = num_in;
			assign den_p  = den_in;
			assign side_p = side_in;
			assign vld_p  = vld_in;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign shf_p  = shf_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		// Shift in the next dividend bit and try the subtraction
		assign trial = {rem_p, shf_p[Q_W-1]};
		assign diff  = trial - {1'b0, den_p};
		assign ge    = (trial >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				shf_s[k]  <= {shf_p[Q_W-2:0], ge};
				den_s[k]  <= den_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign vld_out  = vld_s[Q_W-1];
	assign quo_out  = shf_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

[design/pgf_sqrt.sv]
// ----------------------------------------------------------------------------
// pgf_sqrt: pipelined integer square root
// Digit-by-digit root of a normalized radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module pgf_sqrt
	import pgf_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [NORM_W-1:0] rad_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [ROOT_W-1:0] root_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [NORM_W-1:0] v_s    [SQRT_STAGES];
	logic [NORM_W-1:0] r_s    [SQRT_STAGES];
	logic [SIDE_W-1:0] side_s [SQRT_STAGES];
	logic              vld_s  [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [NORM_W-1:0] BIT = NORM_W'(1) << (NORM_W - 2 - 2 * k);
		logic [NORM_W-1:0] v_p;
		logic [NORM_W-1:0] r_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [NORM_W-1:0] trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_p    = rad_in;
			assign r_p    = '0;
			assign side_p = side_in;
			assign vld_p  = vld_in;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign r_p    = r_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign trial = r_p + BIT;
		assign ge    = (v_p >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		// Accept the trial bit when the remainder covers it
		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k]    <= ge ? (v_p - trial) : v_p;
				r_s[k]    <= ge ? ((r_p >> 1) + BIT) : (r_p >> 1);
				side_s[k] <= side_p;
			end
		end
	end

	assign vld_out  = vld_s[SQRT_STAGES-1];
	assign root_out = r_s[SQRT_STAGES-1][ROOT_W-1:0];
	assign side_out = side_s[SQRT_STAGES-1];

endmodule

[design/pairwise_gravity_force.sv]
// ----------------------------------------------------------------------------
// pairwise_gravity_force: 2D gravitational pull of one body on another
// Fixed-point force along the unit vector, squared distance clamped.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         body pair, tdata 128 bits
//  m_*       out        force vector, tdata 64 bits, tuser saturated flag
//  cfg_*     in         register writes, no read-back
//
//  One pair per cycle sustained while the output is not stalled; 70
//  register stages. The 64-stage magnitude divider sets that depth, with
//  the 31-stage square root and 31-stage unit divider running beside it.
//  Reset clears all valid bits and loads the register defaults.
//  The whole pipeline holds when the output register is full and not taken.
// ----------------------------------------------------------------------------
module pairwise_gravity_force
	import pgf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// first_x, first_y, first_mass, second_x, second_y, second_mass
	input  logic [127:0]         s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// force_x, force_y
	output logic [63:0]          m_tdata,
	// saturated
	output logic [0:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DSQ_W-1:0]     cfg_data
);

	localparam int D_W   = POS_W + 1;
	localparam int S_W   = 2 * D_W;
	localparam int T_W   = 5;
	localparam int SQ_SIDE_W = T_W + 2 * D_W + 2;

	// Configuration registers
	logic [GRAV_W-1:0] grav_q;
	logic [DSQ_W-1:0]  min_q;
	logic [DSQ_W-1:0]  max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAV_RESET;
			min_q  <= MIN_DSQ_RESET;
			max_q  <= MAX_DSQ_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRAV_CONSTANT: grav_q <= cfg_data[GRAV_W-1:0];
				REG_MIN_DIST_SQ:   min_q  <= cfg_data;
				REG_MAX_DIST_SQ:   max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic vld_s70;
	assign adv      = ~vld_s70 | m_tready;
	assign s_tready = adv;

	// Stage 1: differences, magnitudes, G * first_mass
	logic [POS_W-1:0]  fx_in, fy_in, sx_in, sy_in;
	logic [MASS_W-1:0] fm_in, sm_in;
	logic [D_W-1:0]    dx, dy;
	assign fx_in = s_tdata[23:0];
	assign fy_in = s_tdata[47:24];
	assign fm_in = s_tdata[63:48];
	assign sx_in = s_tdata[87:64];
	assign sy_in = s_tdata[111:88];
	assign sm_in = s_tdata[127:112];
	assign dx = {sx_in[POS_W-1], sx_in} - {fx_in[POS_W-1], fx_in};
	assign dy = {sy_in[POS_W-1], sy_in} - {fy_in[POS_W-1], fy_in};

	logic                     vld_s1;
	logic [D_W-1:0]           adx_s1, ady_s1;
	logic                     negx_s1, negy_s1;
	logic [GRAV_W+MASS_W-1:0] ga_s1;
	logic [MASS_W-1:0]        mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			negx_s1 <= dx[D_W-1];
			negy_s1 <= dy[D_W-1];
			adx_s1  <= dx[D_W-1] ? (D_W'(0) - dx) : dx;
			ady_s1  <= dy[D_W-1] ? (D_W'(0) - dy) : dy;
			ga_s1   <= grav_q * fm_in;
			mb_s1   <= sm_in;
		end
	end

	// Stage 2: squared distance and full numerator
	logic                            vld_s2;
	logic [S_W-1:0]                  s_s2;
	logic [GRAV_W+2*MASS_W-1:0]      num_s2;
	logic [D_W-1:0]                  adx_s2, ady_s2;
	logic                            negx_s2, negy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2    <= (S_W'(adx_s1) * S_W'(adx_s1)) + (S_W'(ady_s1) * S_W'(ady_s1));
			num_s2  <= ga_s1 * mb_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
		end
	end

	// Stage 3: clamp, first normalize steps
	logic [DSQ_W-1:0]  s_ext, c_raw;
	logic [NORM_W-1:0] n0, n1, n2;
	logic [T_W-1:0]    t1, t2;
	assign s_ext = DSQ_W'(s_s2);
	assign c_raw = (s_ext < min_q) ? min_q : ((s_ext > max_q) ? max_q : s_ext);
	assign n0 = NORM_W'(s_s2);
	assign n1 = (n0[NORM_W-1 -: 32] == '0) ? (n0 << 32) : n0;
	assign t1 = (n0[NORM_W-1 -: 32] == '0) ? T_W'(16) : T_W'(0);
	assign n2 = (n1[NORM_W-1 -: 16] == '0) ? (n1 << 16) : n1;
	assign t2 = (n1[NORM_W-1 -: 16] == '0) ? (t1 + T_W'(8)) : t1;

	logic                       vld_s3;
	logic [DSQ_W-1:0]           c_s3;
	logic [GRAV_W+2*MASS_W-1:0] num_s3;
	logic                       zero_s3;
	logic [NORM_W-1:0]          nrm_s3;
	logic [T_W-1:0]             t_s3;
	logic [D_W-1:0]             adx_s3, ady_s3;
	logic                       negx_s3, negy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3    <= (c_raw == '0) ? DSQ_W'(1) : c_raw;
			num_s3  <= num_s2;
			zero_s3 <= (s_s2 == '0);
			nrm_s3  <= n2;
			t_s3    <= t2;
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
		end
	end

	// Stage 4: finish normalize so the top bit pair is nonzero
	logic [NORM_W-1:0] n3, n4, n5;
	logic [T_W-1:0]    t3, t4, t5;
	assign n3 = (nrm_s3[NORM_W-1 -: 8] == '0) ? (nrm_s3 << 8) : nrm_s3;
	assign t3 = (nrm_s3[NORM_W-1 -: 8] == '0) ? (t_s3 + T_W'(4)) : t_s3;
	assign n4 = (n3[NORM_W-1 -: 4] == '0) ? (n3 << 4) : n3;
	assign t4 = (n3[NORM_W-1 -: 4] == '0) ? (t3 + T_W'(2)) : t3;
	assign n5 = (n4[NORM_W-1 -: 2] == '0) ? (n4 << 2) : n4;
	assign t5 = (n4[NORM_W-1 -: 2] == '0) ? (t4 + T_W'(1)) : t4;

	logic                       vld_s4;
	logic [DSQ_W-1:0]           c_s4;
	logic [GRAV_W+2*MASS_W-1:0] num_s4;
	logic                       zero_s4;
	logic [NORM_W-1:0]          nrm_s4;
	logic [SQ_SIDE_W-1:0]       sq_side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4       <= c_s3;
			num_s4     <= num_s3;
			zero_s4    <= zero_s3;
			nrm_s4     <= n5;
			sq_side_s4 <= {t5, adx_s3, ady_s3, negx_s3, negy_s3};
		end
	end

	// Stages 5 to 68: magnitude = numerator / clamped distance
	logic                       mag_vld;
	logic [GRAV_W+2*MASS_W-1:0] mag;
	logic                       mag_zero;

	pgf_div #(
		.DEN_W  (DSQ_W),
		.Q_W    (GRAV_W + 2 * MASS_W),
		.SIDE_W (1)
	) u_mag_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s4),
		.rem_in   ('0),
		.num_in   (num_s4),
		.den_in   (c_s4),
		.side_in  (zero_s4),
		.vld_out  (mag_vld),
		.quo_out  (mag),
		.side_out (mag_zero)
	);

	// Stages 5 to 35: length of the normalized difference
	logic                 sq_vld;
	logic [ROOT_W-1:0]    len;
	logic [SQ_SIDE_W-1:0] sq_side;

	pgf_sqrt #(
		.SIDE_W (SQ_SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s4),
		.rad_in   (nrm_s4),
		.side_in  (sq_side_s4),
		.vld_out  (sq_vld),
		.root_out (len),
		.side_out (sq_side)
	);

	// Stage 36: scale the components by the normalize shift of the root
	logic [T_W-1:0]         sq_t;
	logic [D_W-1:0]         sq_adx, sq_ady;
	logic                   sq_negx, sq_negy;
	logic [D_W+30-1:0]      ax_wide, ay_wide;
	assign {sq_t, sq_adx, sq_ady, sq_negx, sq_negy} = sq_side;
	assign ax_wide = (D_W + 30)'(sq_adx) << sq_t;
	assign ay_wide = (D_W + 30)'(sq_ady) << sq_t;

	logic              vld_s36;
	logic [ROOT_W-1:0] ax_s36, ay_s36, len_s36;
	logic              negx_s36, negy_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s36 <= 1'b0;
		end else if (adv) begin
			vld_s36 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s36   <= ax_wide[ROOT_W-1:0];
			ay_s36   <= ay_wide[ROOT_W-1:0];
			len_s36  <= len;
			negx_s36 <= sq_negx;
			negy_s36 <= sq_negy;
		end
	end

	// Stages 37 to 67: unit vector components, Q.30
	logic              ux_vld, uy_vld;
	logic [ROOT_W-1:0] ux, uy;
	logic              ux_neg, uy_neg;

	pgf_div #(
		.DEN_W  (ROOT_W),
		.Q_W    (ROOT_W),
		.SIDE_W (1)
	) u_ux_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s36),
		.rem_in   ({1'b0, ax_s36[ROOT_W-1:1]}),
		.num_in   ({ax_s36[0], (ROOT_W-1)'(0)}),
		.den_in   (len_s36),
		.side_in  (negx_s36),
		.vld_out  (ux_vld),
		.quo_out  (ux),
		.side_out (ux_neg)
	);

	pgf_div #(
		.DEN_W  (ROOT_W),
		.Q_W    (ROOT_W),
		.SIDE_W (1)
	) u_uy_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s36),
		.rem_in   ({1'b0, ay_s36[ROOT_W-1:1]}),
		.num_in   ({ay_s36[0], (ROOT_W-1)'(0)}),
		.den_in   (len_s36),
		.side_in  (negy_s36),
		.vld_out  (uy_vld),
		.quo_out  (uy),
		.side_out (uy_neg)
	);

	// Stage 68: align unit vector with the magnitude
	logic              vld_s68;
	logic [ROOT_W-1:0] ux_s68, uy_s68;
	logic              negx_s68, negy_s68;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s68 <= 1'b0;
		end else if (adv) begin
			vld_s68 <= ux_vld & uy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s68   <= ux;
			uy_s68   <= uy;
			negx_s68 <= ux_neg;
			negy_s68 <= uy_neg;
		end
	end

	// Stage 69: partial products of magnitude times unit component
	localparam int P_W = 32 + ROOT_W;
	logic           vld_s69;
	logic [P_W-1:0] plox_s69, phix_s69, ploy_s69, phiy_s69;
	logic           negx_s69, negy_s69, zero_s69;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s69 <= 1'b0;
		end else if (adv) begin
			vld_s69 <= vld_s68 & mag_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plox_s69 <= P_W'(mag[31:0]) * P_W'(ux_s68);
			phix_s69 <= P_W'(mag[63:32]) * P_W'(ux_s68);
			ploy_s69 <= P_W'(mag[31:0]) * P_W'(uy_s68);
			phiy_s69 <= P_W'(mag[63:32]) * P_W'(uy_s68);
			negx_s69 <= negx_s68;
			negy_s69 <= negy_s68;
			zero_s69 <= mag_zero;
		end
	end

	// Combine, saturate toward the sign limit, apply sign
	function automatic logic [FORCE_W:0] finish(input logic [P_W-1:0] plo,
			input logic [P_W-1:0] phi, input logic neg);
		logic [FORCE_W+1:0] val;
		logic [FORCE_W+1:0] lim;
		logic               sat;
		lim = neg ? {2'b00, FORCE_MIN} : {2'b00, FORCE_MAX};
		val = {2'b00, phi[29:0], 2'b00} + {1'b0, plo[P_W-1:30]};
		sat = (phi[P_W-1:30] != '0) || (val > lim);
		if (sat) begin
			val = lim;
		end
		return {sat, neg ? (FORCE_W'(0) - val[FORCE_W-1:0]) : val[FORCE_W-1:0]};
	endfunction

	logic [FORCE_W:0] resx, resy;
	assign resx = finish(plox_s69, phix_s69, negx_s69);
	assign resy = finish(ploy_s69, phiy_s69, negy_s69);

	// Stage 70: output register
	logic [FORCE_W-1:0] fx_s70, fy_s70;
	logic               sat_s70;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s70 <= 1'b0;
		end else if (adv) begin
			vld_s70 <= vld_s69;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s70  <= zero_s69 ? '0 : resx[FORCE_W-1:0];
			fy_s70  <= zero_s69 ? '0 : resy[FORCE_W-1:0];
			sat_s70 <= ~zero_s69 & (resx[FORCE_W] | resy[FORCE_W]);
		end
	end

	assign m_tvalid = vld_s70;
	assign m_tdata  = {fy_s70, fx_s70};
	assign m_tuser  = sat_s70;

endmodule

[design/pgf_checker.sv]
// ----------------------------------------------------------------------------
// pgf_checker: port-level checks for the pairwise gravity force block
// Watches the stream ports and the saturation flag.
// ----------------------------------------------------------------------------
module pgf_checker
	import pgf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Input side opens exactly when the output register can advance
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output side");

	// A saturated result shows a component at a limit
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[31:0] == FORCE_MAX || m_tdata[31:0] == FORCE_MIN ||
			m_tdata[63:32] == FORCE_MAX || m_tdata[63:32] == FORCE_MIN)
		else $error("saturation flag without a clipped component");

endmodule

bind pairwise_gravity_force pgf_checker u_pgf_checker (.*);
